/* rtl/tmcw_pkg.sv */
// Shared constants for the text mode console writer.
`default_nettype none

package tmcw_pkg;

	// Default screen geometry.
	localparam int DEF_COLUMNS = 80;
	localparam int DEF_ROWS    = 25;

	// Field widths.
	localparam int CHAR_W   = 8;
	localparam int ATTR_W   = 8;
	localparam int CELL_W   = ATTR_W + CHAR_W;
	localparam int IDX_W    = 11;
	localparam int CURSOR_W = 12;
	localparam int SCROLL_W = 6;
	localparam int TOP_W    = 5;

	// Configuration port.
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 8;
	localparam logic [CFG_IDX_W-1:0] REG_ATTRIBUTE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TOP_LINE  = 1'd1;

	// Register reset values.
	localparam logic [ATTR_W-1:0] ATTR_RESET = 8'd7;
	localparam int                TOP_RESET  = 2;

	// Saturation limits.
	localparam int                  CURSOR_MAX = 4095;
	localparam logic [SCROLL_W-1:0] SCROLL_MAX = 6'd63;

	// Command and character codes.
	localparam logic FUNC_PUT  = 1'b0;
	localparam logic FUNC_READ = 1'b1;
	localparam logic [CHAR_W-1:0] CHAR_NUL = 8'd0;
	localparam logic [CHAR_W-1:0] CHAR_LF  = 8'd10;
	localparam logic [CHAR_W-1:0] CHAR_CR  = 8'd13;

endpackage

`default_nettype wire

/* rtl/tmcw_ram.sv */
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none

module tmcw_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

/* rtl/text_mode_console_writer.sv */
// Top level of the text mode console writer: screen store, cursor and scroll sequencer.
`default_nettype none

// A screen of ROWS x COLUMNS cells, each holding an attribute byte above a
// character byte, kept in one RAM, plus a linear cursor. A command word is
// taken when start is high and busy is low; its result appears for exactly
// one cycle with done high, and the receiver cannot stall it. A put of a
// line feed, carriage return, zero byte or of a character that needs no
// scroll, and a read outside the screen, keep busy low: the next word can
// follow at once and the result shows on the following cycle. A read inside
// the screen keeps busy high through the registered RAM read. A character
// written while the cursor lies past the screen first scrolls: each scroll
// runs a setup state, a copy that moves the rows below top_line up by one,
// a drain state and a clear of the last row (one RAM cell moved or cleared
// per cycle); the copy is skipped when top_line is at or below the last
// row. Then the character is stored. After reset a clearing pass zeroes
// the screen; busy stays high meanwhile. Configuration writes are always
// ready and must only be made while the block is idle.

module text_mode_console_writer #(
	parameter int COLUMNS = tmcw_pkg::DEF_COLUMNS,
	parameter int ROWS    = tmcw_pkg::DEF_ROWS
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	// Command side.
	input  wire logic                            start,
	output logic                                 busy,
	input  wire logic                            func,
	input  wire logic [tmcw_pkg::CHAR_W-1:0]     char_code,
	input  wire logic [tmcw_pkg::IDX_W-1:0]      cell_index,
	// Result side.
	output logic                                 done,
	output logic      [tmcw_pkg::CELL_W-1:0]     cell_value,
	output logic      [tmcw_pkg::CURSOR_W-1:0]   cursor_pos,
	output logic      [tmcw_pkg::SCROLL_W-1:0]   scroll_count,
	// Configuration write channel.
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [tmcw_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [tmcw_pkg::CFG_DATA_W-1:0] cfg_data
);

	localparam int CELLS = COLUMNS * ROWS;
	localparam int AW    = $clog2(CELLS);
	localparam int CW    = $clog2(COLUMNS);

	localparam logic [AW-1:0] LAST_CELL     = AW'(CELLS - 1);
	localparam logic [AW-1:0] LAST_ROW_BASE = AW'((ROWS - 1) * COLUMNS);
	localparam logic [AW-1:0] COLS_A        = AW'(COLUMNS);
	localparam logic [CW-1:0] LAST_COL      = CW'(COLUMNS - 1);

	// The cursor is kept together with its column so that no division is
	// needed for line feed and carriage return.
	localparam int RST_CURSOR_I = (tmcw_pkg::TOP_RESET * COLUMNS > tmcw_pkg::CURSOR_MAX) ?
		tmcw_pkg::CURSOR_MAX : tmcw_pkg::TOP_RESET * COLUMNS;
	localparam logic [tmcw_pkg::CURSOR_W-1:0] RST_CURSOR = tmcw_pkg::CURSOR_W'(RST_CURSOR_I);
	localparam logic [CW-1:0] RST_COL = CW'(RST_CURSOR_I % COLUMNS);
	localparam logic [tmcw_pkg::CURSOR_W-1:0] CURSOR_SAT = tmcw_pkg::CURSOR_W'(tmcw_pkg::CURSOR_MAX);
	localparam logic [CW-1:0] SAT_COL = CW'(tmcw_pkg::CURSOR_MAX % COLUMNS);
	localparam logic [tmcw_pkg::CURSOR_W-1:0] COLS_C = tmcw_pkg::CURSOR_W'(COLUMNS);

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_READ,
		ST_SCROLL,
		ST_COPY,
		ST_DRAIN,
		ST_CLEAR
	} state_t;

	state_t                            state_q;
	logic [tmcw_pkg::CURSOR_W-1:0]     cursor_q;
	logic [CW-1:0]                     col_q;
	logic [tmcw_pkg::ATTR_W-1:0]       attr_q;
	logic [tmcw_pkg::TOP_W-1:0]        top_q;
	logic [tmcw_pkg::CHAR_W-1:0]       char_q;
	logic [tmcw_pkg::SCROLL_W-1:0]     scrolls_q;
	logic [tmcw_pkg::CELL_W-1:0]       cell_value_q;
	logic                              done_q;
	logic [AW-1:0]                     src_q;
	logic [AW-1:0]                     clr_q;
	logic                              valid_s1;
	logic [AW-1:0]                     waddr_s1;

	logic                              ram_we;
	logic [AW-1:0]                     ram_waddr;
	logic [tmcw_pkg::CELL_W-1:0]       ram_wdata;
	logic                              ram_re;
	logic [AW-1:0]                     ram_raddr;
	logic [tmcw_pkg::CELL_W-1:0]       ram_rdata;

	logic                              accept;
	logic                              is_glyph;
	logic                              idx_ok;
	logic                              cur_off;
	logic                              has_copy;
	logic [AW-1:0]                     copy_start;
	logic [tmcw_pkg::CURSOR_W-1:0]     adv_cursor;
	logic [CW-1:0]                     adv_col;
	logic [tmcw_pkg::CURSOR_W-1:0]     row_base;
	logic [tmcw_pkg::CURSOR_W:0]       lf_sum;
	logic [tmcw_pkg::CURSOR_W-1:0]     lf_cursor;
	logic [CW-1:0]                     lf_col;

	assign busy         = (state_q != ST_IDLE);
	assign accept       = start && !busy;
	assign cfg_ready    = 1'b1;
	assign done         = done_q;
	assign cell_value   = cell_value_q;
	assign cursor_pos   = cursor_q;
	assign scroll_count = scrolls_q;

	// Command decode and cursor arithmetic.
	always_comb begin
		is_glyph = (func == tmcw_pkg::FUNC_PUT) && (char_code != tmcw_pkg::CHAR_LF) &&
			(char_code != tmcw_pkg::CHAR_CR) && (char_code != tmcw_pkg::CHAR_NUL);
		idx_ok   = (32'(cell_index) < 32'(CELLS));
		cur_off  = (32'(cursor_q) >= 32'(CELLS));
		has_copy = (32'(top_q) + 32'd1 < 32'(ROWS));
		copy_start = AW'((32'(top_q) + 32'd1) * 32'(COLUMNS));

		// Advance by one cell; a saturated cursor stays where it is.
		if (cursor_q == CURSOR_SAT) begin
			adv_cursor = cursor_q;
			adv_col    = col_q;
		end else begin
			adv_cursor = cursor_q + 1'b1;
			adv_col    = (col_q == LAST_COL) ? '0 : col_q + 1'b1;
		end

		// Start of the current row, and of the next one with saturation.
		row_base = cursor_q - tmcw_pkg::CURSOR_W'(col_q);
		lf_sum   = {1'b0, row_base} + {1'b0, COLS_C};
		if (lf_sum[tmcw_pkg::CURSOR_W]) begin
			lf_cursor = CURSOR_SAT;
			lf_col    = SAT_COL;
		end else begin
			lf_cursor = lf_sum[tmcw_pkg::CURSOR_W-1:0];
			lf_col    = '0;
		end
	end

	// RAM port control. Copy reads always run one row ahead of the copy
	// writes, so a read never meets a cell written in the same pass.
	always_comb begin
		ram_we    = valid_s1;
		ram_waddr = waddr_s1;
		ram_wdata = ram_rdata;
		ram_re    = 1'b0;
		ram_raddr = src_q;
		case (state_q)
			ST_INIT, ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
				ram_wdata = '0;
			end
			ST_IDLE: begin
				if (accept && (func == tmcw_pkg::FUNC_READ) && idx_ok) begin
					ram_re    = 1'b1;
					ram_raddr = AW'(cell_index);
				end
				if (accept && is_glyph && !cur_off) begin
					ram_we    = 1'b1;
					ram_waddr = AW'(cursor_q);
					ram_wdata = {attr_q, char_code};
				end
			end
			ST_SCROLL: begin
				if (!cur_off) begin
					ram_we    = 1'b1;
					ram_waddr = AW'(cursor_q);
					ram_wdata = {attr_q, char_q};
				end
			end
			ST_COPY: begin
				ram_re = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_INIT;
			cursor_q     <= RST_CURSOR;
			col_q        <= RST_COL;
			attr_q       <= tmcw_pkg::ATTR_RESET;
			top_q        <= tmcw_pkg::TOP_W'(tmcw_pkg::TOP_RESET);
			char_q       <= '0;
			scrolls_q    <= '0;
			cell_value_q <= '0;
			done_q       <= 1'b0;
			src_q        <= '0;
			clr_q        <= '0;
			valid_s1     <= 1'b0;
			waddr_s1     <= '0;
		end else begin
			done_q   <= 1'b0;
			valid_s1 <= ram_re && (state_q == ST_COPY);
			waddr_s1 <= src_q - COLS_A;

			if (cfg_valid) begin
				case (cfg_index)
					tmcw_pkg::REG_ATTRIBUTE: attr_q <= cfg_data;
					tmcw_pkg::REG_TOP_LINE:  top_q  <= cfg_data[tmcw_pkg::TOP_W-1:0];
					default: begin
					end
				endcase
			end

			case (state_q)
				ST_INIT: begin
					// Zero every cell once after reset.
					if (clr_q == LAST_CELL) begin
						clr_q   <= '0;
						state_q <= ST_IDLE;
					end else begin
						clr_q <= clr_q + 1'b1;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						scrolls_q    <= '0;
						cell_value_q <= '0;
						if (func == tmcw_pkg::FUNC_READ) begin
							if (idx_ok) begin
								state_q <= ST_READ;
							end else begin
								done_q <= 1'b1;
							end
						end else if (char_code == tmcw_pkg::CHAR_LF) begin
							cursor_q <= lf_cursor;
							col_q    <= lf_col;
							done_q   <= 1'b1;
						end else if (char_code == tmcw_pkg::CHAR_CR) begin
							cursor_q <= row_base;
							col_q    <= '0;
							done_q   <= 1'b1;
						end else if (char_code == tmcw_pkg::CHAR_NUL) begin
							done_q <= 1'b1;
						end else if (cur_off) begin
							char_q  <= char_code;
							state_q <= ST_SCROLL;
						end else begin
							cursor_q <= adv_cursor;
							col_q    <= adv_col;
							done_q   <= 1'b1;
						end
					end
				end
				ST_READ: begin
					cell_value_q <= ram_rdata;
					done_q       <= 1'b1;
					state_q      <= ST_IDLE;
				end
				ST_SCROLL: begin
					// Either start another scroll or store the held character.
					if (cur_off) begin
						if (has_copy) begin
							src_q   <= copy_start;
							state_q <= ST_COPY;
						end else begin
							clr_q   <= LAST_ROW_BASE;
							state_q <= ST_CLEAR;
						end
					end else begin
						cursor_q <= adv_cursor;
						col_q    <= adv_col;
						done_q   <= 1'b1;
						state_q  <= ST_IDLE;
					end
				end
				ST_COPY: begin
					if (src_q == LAST_CELL) begin
						state_q <= ST_DRAIN;
					end else begin
						src_q <= src_q + 1'b1;
					end
				end
				ST_DRAIN: begin
					// The last moved cell is written in this cycle.
					clr_q   <= LAST_ROW_BASE;
					state_q <= ST_CLEAR;
				end
				ST_CLEAR: begin
					if (clr_q == LAST_CELL) begin
						cursor_q <= cursor_q - COLS_C;
						if (scrolls_q != tmcw_pkg::SCROLL_MAX) begin
							scrolls_q <= scrolls_q + 1'b1;
						end
						state_q <= ST_SCROLL;
					end else begin
						clr_q <= clr_q + 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	tmcw_ram #(
		.WIDTH(tmcw_pkg::CELL_W),
		.DEPTH(CELLS)
	) u_screen (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

endmodule

`default_nettype wire

/* tb/text_mode_console_writer_tb.sv */
// Self-checking testbench for the text mode console writer: command stimulus, predictor and checks.

module text_mode_console_writer_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import tmcw_pkg::*;

	// Screen geometry as built by the default parameters of the block.
	localparam int COLS  = DEF_COLUMNS;
	localparam int LINES = DEF_ROWS;
	localparam int CELLS = COLS * LINES;
	localparam int IDX_TOP = (1 << IDX_W) - 1;

	// The slowest scroll is the one with top_line at row 0: it moves 24 rows
	// and clears one. A scroll needs the cursor to have moved a full row
	// past the screen, so there are never more scrolls than command words.
	// The limit allows for every word being followed by the slowest scroll,
	// on top of the clearing pass after reset, with room to spare.
	localparam int CYCLE_LIMIT = 20_000_000;

	// One expected result: what a command word should report.
	typedef struct packed {
		logic [CELL_W-1:0]   value;
		logic [CURSOR_W-1:0] cursor;
		logic [SCROLL_W-1:0] scrolls;
	} outcome_t;

	// Screen tracker: mirrors the screen, the cursor and both registers, and
	// holds the outcomes of accepted words until the block reports them.
	class console_tracker;
		logic [CELL_W-1:0] cells [CELLS];
		logic [ATTR_W-1:0] attr;
		int                top;
		int                cursor;
		outcome_t          awaited [$];
		int                errors;
		int                words;
		int                reads;
		int                scrolls_total;
		int                peak;

		function new();
			foreach (cells[i])
				cells[i] = '0;
			attr          = ATTR_RESET;
			top           = TOP_RESET;
			cursor        = TOP_RESET * COLS;
			errors        = 0;
			words         = 0;
			reads         = 0;
			scrolls_total = 0;
			peak          = cursor;
		endfunction

		function int pending();
			return awaited.size();
		endfunction

		function int clip_cursor(input int v);
			return (v > CURSOR_MAX) ? CURSOR_MAX : v;
		endfunction

		function void set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
			if (idx == REG_ATTRIBUTE) begin
				attr = data;
			end else if (idx == REG_TOP_LINE) begin
				top = int'(data[TOP_W-1:0]);
			end
		endfunction

		// One scroll: rows from top_line down move up by one, the last row
		// is blanked. With top_line on the last row only the blanking is left.
		function void scroll_region();
			for (int r = top; r + 1 < LINES; r++)
				for (int c = 0; c < COLS; c++)
					cells[r * COLS + c] = cells[(r + 1) * COLS + c];
			for (int c = 0; c < COLS; c++)
				cells[(LINES - 1) * COLS + c] = '0;
		endfunction

		function void take_word(input logic f, input logic [CHAR_W-1:0] ch,
				input logic [IDX_W-1:0] idx);
			outcome_t o;
			int       n;
			o = '0;
			words++;
			if (f == FUNC_READ) begin
				reads++;
				if (int'(idx) < CELLS)
					o.value = cells[idx];
			end else if (ch == CHAR_LF) begin
				// The next row start is worked out at full width and only then clipped.
				n = cursor + COLS;
				cursor = clip_cursor(n - n % COLS);
			end else if (ch == CHAR_CR) begin
				cursor = cursor - cursor % COLS;
			end else if (ch != CHAR_NUL) begin
				while (cursor >= CELLS) begin
					scroll_region();
					cursor -= COLS;
					scrolls_total++;
					if (o.scrolls < SCROLL_MAX)
						o.scrolls++;
				end
				cells[cursor] = {attr, ch};
				cursor = clip_cursor(cursor + 1);
			end
			o.cursor = cursor[CURSOR_W-1:0];
			if (cursor > peak)
				peak = cursor;
			awaited.push_back(o);
		endfunction

		task report(input string what);
			$display("MISMATCH at %0t: %s", $realtime, what);
			errors++;
		endtask

		task compare_result(input logic [CELL_W-1:0] value, input logic [CURSOR_W-1:0] cur,
				input logic [SCROLL_W-1:0] sc);
			outcome_t want;
			if (awaited.size() == 0) begin
				report($sformatf("result %h/%0d/%0d with no word outstanding", value, cur, sc));
				return;
			end
			want = awaited.pop_front();
			if (value !== want.value)
				report($sformatf("cell_value %h, expected %h", value, want.value));
			if (cur !== want.cursor)
				report($sformatf("cursor_pos %0d, expected %0d", cur, want.cursor));
			if (sc !== want.scrolls)
				report($sformatf("scroll_count %0d, expected %0d", sc, want.scrolls));
		endtask
	endclass

	// Every input of the block starts at a known value.
	logic                  clk        = 1'b0;
	logic                  arst_n     = 1'b0;
	logic                  start      = 1'b0;
	logic                  func       = FUNC_PUT;
	logic [CHAR_W-1:0]     char_code  = '0;
	logic [IDX_W-1:0]      cell_index = '0;
	logic                  cfg_valid  = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index  = '0;
	logic [CFG_DATA_W-1:0] cfg_data   = '0;
	logic                  busy;
	logic                  done;
	logic [CELL_W-1:0]     cell_value;
	logic [CURSOR_W-1:0]   cursor_pos;
	logic [SCROLL_W-1:0]   scroll_count;
	logic                  cfg_ready;

	console_tracker tracker = new();

	int cycles     = 0;
	int issued     = 0;
	int burst_left = 1;
	int settings   = 0;

	text_mode_console_writer u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.func         (func),
		.char_code    (char_code),
		.cell_index   (cell_index),
		.done         (done),
		.cell_value   (cell_value),
		.cursor_pos   (cursor_pos),
		.scroll_count (scroll_count),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #10 clk = ~clk;

	// Monitor. Everything is sampled at the rising edge, before the block's
	// registers move. A result is checked before a word accepted at the same
	// edge is predicted, so the oldest outcome always meets the oldest result.
	always @(posedge clk) begin
		if (arst_n) begin
			if (done)
				tracker.compare_result(cell_value, cursor_pos, scroll_count);
			if (start && !busy)
				tracker.take_word(func, char_code, cell_index);
			if (cfg_valid && cfg_ready)
				tracker.set_reg(cfg_index, cfg_data);
		end
	end

	// Watchdog: a hung handshake or a lost result ends the run here.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("Cycle limit reached with %0d results outstanding.", tracker.pending());
			$display("[text_mode_console_writer] ERROR");
			$finish;
		end
	end

	// Presents one command word from the falling edge on and holds it until
	// the block takes it. Start stays high afterwards, so whatever follows
	// must either present the next word or lower start at the next falling edge.
	task automatic send_word(input logic f, input logic [CHAR_W-1:0] ch,
			input logic [IDX_W-1:0] idx);
		@(negedge clk);
		start      <= 1'b1;
		func       <= f;
		char_code  <= ch;
		cell_index <= idx;
		do
			@(posedge clk);
		while (busy);
	endtask

	// A gap in the command stream; the fields carry junk while start is low.
	task automatic pause_input(input int n);
		@(negedge clk);
		start      <= 1'b0;
		func       <= 1'($urandom_range(0, 1));
		char_code  <= CHAR_W'($urandom_range(0, 255));
		cell_index <= IDX_W'($urandom_range(0, IDX_TOP));
		repeat (n - 1)
			@(negedge clk);
	endtask

	// Holds the command stream until every outstanding result has come back.
	task automatic wait_all_results();
		@(negedge clk);
		start <= 1'b0;
		while (tracker.pending() != 0)
			@(negedge clk);
	endtask

	// Brings the block to rest before the registers are touched. Every word
	// yields a result, so no work can hide behind the last one; the extra
	// cycles and the busy check are cheap insurance.
	task automatic quiesce();
		wait_all_results();
		repeat (4)
			@(negedge clk);
		while (busy)
			@(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do
			@(posedge clk);
		while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_screen_mode(input logic [ATTR_W-1:0] a, input int t);
		quiesce();
		write_reg(REG_ATTRIBUTE, a);
		write_reg(REG_TOP_LINE, CFG_DATA_W'(t));
		settings++;
	endtask

	// Sends one word inside the current burst. When a burst runs out the
	// sender usually pauses, but some bursts run back to back so that long
	// stretches go by with no gap at all. Now and then the sender also
	// waits until every result is in.
	task automatic emit(input logic f, input logic [CHAR_W-1:0] ch, input logic [IDX_W-1:0] idx);
		send_word(f, ch, idx);
		issued++;
		burst_left--;
		if (burst_left <= 0) begin
			if ($urandom_range(0, 9) < 7)
				pause_input($urandom_range(1, 8));
			burst_left = $urandom_range(1, 40);
		end
		if ($urandom_range(0, 199) == 0)
			wait_all_results();
	endtask

	task automatic put_char(input logic [CHAR_W-1:0] ch);
		emit(FUNC_PUT, ch, IDX_W'($urandom_range(0, IDX_TOP)));
	endtask

	task automatic read_cell(input logic [IDX_W-1:0] idx);
		emit(FUNC_READ, CHAR_W'($urandom_range(0, 255)), idx);
	endtask

	// Mostly printable text; one byte in eight is any byte but zero, line
	// feed and carriage return, so the character's top bit is exercised often.
	function automatic logic [CHAR_W-1:0] pick_glyph();
		logic [CHAR_W-1:0] c;
		if ($urandom_range(0, 7) == 0) begin
			c = CHAR_W'($urandom_range(1, 255));
			while (c == CHAR_LF || c == CHAR_CR)
				c = CHAR_W'($urandom_range(1, 255));
		end else begin
			c = CHAR_W'($urandom_range(32, 126));
		end
		return c;
	endfunction

	// Half of the reads land on the row just written, so that fresh cells and
	// scrolled rows are checked soon after they change; some go anywhere on
	// the screen and some past its end, where the block must return zero.
	function automatic logic [IDX_W-1:0] pick_cell();
		int sel;
		int hi;
		sel = $urandom_range(0, 19);
		hi  = (tracker.cursor > CELLS - 1) ? CELLS - 1 : tracker.cursor;
		if (sel < 3)
			return IDX_W'($urandom_range(CELLS, IDX_TOP));
		if (sel < 10)
			return IDX_W'($urandom_range(0, CELLS - 1));
		return IDX_W'($urandom_range((hi < COLS) ? 0 : hi - COLS, hi));
	endfunction

	// Random traffic shaped like console output: runs of text, line ends,
	// blank lines, read-backs and the odd run of line feeds that pushes the
	// cursor well past the screen so the next character scrolls many times.
	task automatic random_phase(input int count);
		int stop_at;
		int kind;
		int len;
		stop_at = issued + count;
		while (issued < stop_at) begin
			kind = $urandom_range(0, 99);
			if (kind < 45) begin
				len = $urandom_range(1, 60);
				repeat (len)
					put_char(pick_glyph());
			end else if (kind < 65) begin
				case ($urandom_range(0, 3))
					0: put_char(CHAR_LF);
					1: put_char(CHAR_CR);
					2: put_char(CHAR_NUL);
					default: begin
						put_char(CHAR_CR);
						put_char(CHAR_LF);
					end
				endcase
			end else if (kind < 90) begin
				len = $urandom_range(1, 6);
				repeat (len)
					read_cell(pick_cell());
			end else if (kind < 97) begin
				put_char(CHAR_CR);
				put_char(CHAR_LF);
				len = $urandom_range(1, COLS);
				repeat (len)
					put_char(pick_glyph());
			end else begin
				len = $urandom_range(1, 30);
				repeat (len)
					put_char(CHAR_LF);
			end
		end
	endtask

	initial begin
		logic [ATTR_W-1:0] attr_plan [8];
		int                top_plan  [8];

		// Screen modes: both attribute extremes, top_line on the first and last row
		// and some values in between, in an order that moves the region boundary around.
		attr_plan = '{8'hFF, 8'h00, 8'h00, 8'h00, 8'h80, 8'h00, 8'h01, 8'h00};
		top_plan  = '{24, 0, 2, 23, 0, 24, 12, 0};
		attr_plan[2] = ATTR_W'($urandom_range(0, 255));
		attr_plan[3] = ATTR_W'($urandom_range(0, 255));
		attr_plan[5] = ATTR_W'($urandom_range(0, 255));
		attr_plan[7] = ATTR_W'($urandom_range(0, 255));
		top_plan[4]  = $urandom_range(0, 24);
		top_plan[7]  = $urandom_range(0, 24);

		repeat (5)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed words under the reset settings. The first word waits out
		// the clearing pass through the normal handshake. Reads of the
		// cleared screen, at its last cell and past its end come first; then
		// characters, some with the top bit set, which must not be sign
		// extended, then a zero byte, a carriage return and line feeds.
		read_cell(IDX_W'(0));
		read_cell(IDX_W'(CELLS - 1));
		read_cell(IDX_W'(CELLS));
		read_cell(IDX_W'(IDX_TOP));
		put_char(8'h48);
		put_char(8'hFF);
		put_char(8'h80);
		put_char(8'h01);
		put_char(CHAR_NUL);
		put_char(CHAR_CR);
		put_char(CHAR_LF);
		put_char(CHAR_LF);
		read_cell(IDX_W'(2 * COLS));
		read_cell(IDX_W'(2 * COLS + 1));
		read_cell(IDX_W'(2 * COLS + 3));
		read_cell(IDX_W'(2 * COLS + 4));

		// A character written and read back under an all-zero and an all-ones attribute.
		set_screen_mode(8'h00, 24);
		put_char(8'h61);
		read_cell(IDX_W'(4 * COLS));
		set_screen_mode(8'hFF, 0);
		put_char(8'h7E);
		read_cell(IDX_W'(4 * COLS + 1));
		put_char(CHAR_CR);
		put_char(CHAR_LF);

		// Random phases, one per screen mode. With the scroll region small,
		// scrolls are cheap, so those phases open by running the cursor into
		// its ceiling with line feeds; the next character then scrolls until
		// the cursor is back on the last row.
		for (int p = 0; p < 8; p++) begin
			set_screen_mode(attr_plan[p], top_plan[p]);
			if (top_plan[p] >= 20) begin
				repeat (55)
					put_char(CHAR_LF);
				put_char(CHAR_CR);
				put_char(pick_glyph());
				read_cell(IDX_W'((LINES - 1) * COLS));
			end
			random_phase(250);
		end

		wait_all_results();
		repeat (20)
			@(negedge clk);

		$display("Covered %0d command words, %0d of them reads, under %0d register settings;",
			tracker.words, tracker.reads, settings + 1);
		$display("%0d scrolls were predicted and the cursor went as far as %0d.",
			tracker.scrolls_total, tracker.peak);
		if (tracker.errors == 0) begin
			$display("[text_mode_console_writer] OK");
		end else begin
			$display("%0d mismatches.", tracker.errors);
			$display("[text_mode_console_writer] ERROR");
		end
		$finish;
	end

endmodule
